// ===== rtl/skvt_pkg.sv =====
// skvt_pkg: types, codes and sizes shared by the sorted key/value table
// used by skvt_cell and sorted_key_value_table; no dependencies
package skvt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int POS_W       = 6;
   localparam int CMP_W       = (IDX_W > POS_W) ? IDX_W : POS_W;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_GET    = 2'd2,
      KIND_AT     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_DONE     = 2'd0,
      STAT_REPLACED = 2'd1,
      STAT_MISSING  = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] key;
      logic [31:0]        payload;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] found_key;
      logic [31:0]        found_payload;
      logic [6:0]         entry_count;
   } rsp_type;

   // update broadcast to every cell in the PH_CMP phase of an operation
   typedef struct packed {
      logic insert;
      logic replace;
      logic remove;
   } cell_cmd_type;

endpackage

// ===== rtl/skvt_cell.sv =====
// skvt_cell: one slot of the sorted table, with its compare flags
// depends on skvt_pkg; chained to its neighbors by sorted_key_value_table
module skvt_cell
   import skvt_pkg::*;
(
   input  logic                clock,
   input  logic                accept,
   input  req_type             req_word,
   input  logic [CNT_W-1:0]    count,
   input  logic [IDX_W-1:0]    index,
   input  cell_cmd_type        cmd,
   input  logic signed [31:0]  new_key,
   input  logic [31:0]         new_payload,
   input  logic                left_lt,
   input  logic signed [31:0]  left_key,
   input  logic [31:0]         left_payload,
   input  logic signed [31:0]  right_key,
   input  logic [31:0]         right_payload,
   output logic signed [31:0]  key,
   output logic [31:0]         payload,
   output logic                lt,
   output logic                match
);

   logic signed [31:0] key_ff, key_in;
   logic [31:0]        payload_ff, payload_in;
   logic               lt_ff, lt_in;
   logic               match_ff, match_in;
   logic               in_use;

   assign in_use = CNT_W'(index) < count;

   always_comb begin
      lt_in    = lt_ff;
      match_in = match_ff;
      if (accept) begin
         lt_in = in_use && (key_ff < req_word.key);
         if (req_word.kind == KIND_AT) begin
            match_in = in_use && (CMP_W'(index) == CMP_W'(req_word.position));
         end else begin
            match_in = in_use && (key_ff == req_word.key);
         end
      end
   end

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (cmd.insert && !lt_ff) begin
         // the first slot not below the key takes the new word, the rest move up
         if (left_lt) begin
            key_in     = new_key;
            payload_in = new_payload;
         end else begin
            key_in     = left_key;
            payload_in = left_payload;
         end
      end else if (cmd.replace && match_ff) begin
         payload_in = new_payload;
      end else if (cmd.remove && !lt_ff) begin
         key_in     = right_key;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
      lt_ff      <= lt_in;
      match_ff   <= match_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;
   assign lt      = lt_ff;
   assign match   = match_ff;

endmodule

// ===== rtl/sorted_key_value_table.sv =====
// Sorted key/value table: a row of TABLE_DEPTH cells kept in ascending signed key order.
// At the accept edge each cell compares its key with the request; in the next cycle the
// flags are reduced and, for an insert or a remove, the row shifts one slot right or left.
// busy is high for that one cycle; a new word is taken only while busy is low, whatever
// the occupancy. The result appears on rsp_word with rsp_strobe high for one cycle as busy
// drops; the receiver cannot stall it. No clearing after reset is needed.
module sorted_key_value_table
   import skvt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'b01,
      PH_CMP  = 2'b10
   } phase_type;

   phase_type          phase_ff, phase_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;
   logic               accept;
   cell_cmd_type       cmd;

   logic signed [31:0] cell_key     [TABLE_DEPTH];
   logic [31:0]        cell_payload [TABLE_DEPTH];
   logic               cell_lt      [TABLE_DEPTH];
   logic               cell_match   [TABLE_DEPTH];

   logic               hit;
   logic               full;
   logic signed [31:0] sel_key;
   logic [31:0]        sel_payload;

   assign busy   = (phase_ff == PH_CMP);
   assign accept = start && !busy;

   for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
      logic               l_lt;
      logic signed [31:0] l_key, r_key;
      logic [31:0]        l_pay, r_pay;

      if (j == 0) begin : g_first
         assign l_lt  = 1'b1;
         assign l_key = req_ff.key;
         assign l_pay = req_ff.payload;
      end else begin : g_inner_l
         assign l_lt  = cell_lt[j-1];
         assign l_key = cell_key[j-1];
         assign l_pay = cell_payload[j-1];
      end

      if (j == TABLE_DEPTH - 1) begin : g_last
         assign r_key = cell_key[j];
         assign r_pay = cell_payload[j];
      end else begin : g_inner_r
         assign r_key = cell_key[j+1];
         assign r_pay = cell_payload[j+1];
      end

      skvt_cell u_cell (
         .clock         (clock),
         .accept        (accept),
         .req_word      (req_word),
         .count         (count_ff),
         .index         (IDX_W'(j)),
         .cmd           (cmd),
         .new_key       (req_ff.key),
         .new_payload   (req_ff.payload),
         .left_lt       (l_lt),
         .left_key      (l_key),
         .left_payload  (l_pay),
         .right_key     (r_key),
         .right_payload (r_pay),
         .key           (cell_key[j]),
         .payload       (cell_payload[j]),
         .lt            (cell_lt[j]),
         .match         (cell_match[j])
      );
   end

   // at most one cell matches, so an and-or picks its word
   always_comb begin
      hit         = 1'b0;
      sel_key     = '0;
      sel_payload = '0;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         hit         = hit | cell_match[j];
         sel_key     = sel_key | (cell_key[j] & {32{cell_match[j]}});
         sel_payload = sel_payload | (cell_payload[j] & {32{cell_match[j]}});
      end
   end

   assign full = (count_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      cmd         = '0;
      phase_in    = phase_ff;
      req_in      = req_ff;
      count_in    = count_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               req_in   = req_word;
               phase_in = PH_CMP;
            end
         end
         PH_CMP: begin
            phase_in                = PH_IDLE;
            strobe_in               = 1'b1;
            rsp_in.status           = STAT_DONE;
            rsp_in.found_key        = hit ? sel_key : '0;
            rsp_in.found_payload    = hit ? sel_payload : '0;
            case (req_ff.kind)
               KIND_ADD: begin
                  rsp_in.found_key     = '0;
                  rsp_in.found_payload = '0;
                  if (hit) begin
                     cmd.replace   = 1'b1;
                     rsp_in.status = STAT_REPLACED;
                  end else if (full) begin
                     rsp_in.status = STAT_FULL;
                  end else begin
                     cmd.insert = 1'b1;
                     count_in   = count_ff + CNT_W'(1);
                  end
               end
               KIND_REMOVE: begin
                  if (hit) begin
                     cmd.remove = 1'b1;
                     count_in   = count_ff - CNT_W'(1);
                  end else begin
                     rsp_in.status = STAT_MISSING;
                  end
               end
               default: begin
                  if (!hit) begin
                     rsp_in.status = STAT_MISSING;
                  end
               end
            endcase
            rsp_in.entry_count = 7'(count_in);
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy ##1 (rsp_strobe && !busy))
      else $error("operation did not finish in two cycles");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_word.status == STAT_FULL) |-> full)
      else $error("full reported with room left");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !busy |=> $stable(count_ff))
      else $error("entry count moved outside an operation");

endmodule
